// ===== sv/mefuf_pkg.sv =====
package mefuf_pkg;

  localparam int MAX_VERTICES = 1024;

  localparam int VERT_W   = 11;
  localparam int WEIGHT_W = 32;
  localparam int COUNT_W  = 10;
  localparam int VIDX_W   = $clog2(MAX_VERTICES);
  localparam int SIZE_W   = $clog2(MAX_VERTICES + 1);
  localparam int CMP_W    = (VERT_W > SIZE_W) ? VERT_W : SIZE_W;
  localparam int EPOCH_W  = 6;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_VERTEX_COUNT   = '0;
  localparam logic [VERT_W-1:0]    VERTEX_COUNT_RESET = VERT_W'(1024);
  localparam logic [VIDX_W-1:0]    LAST_VIDX          = VIDX_W'(MAX_VERTICES - 1);

  typedef enum logic [1:0] {
    ST_JOINED = 2'd0,
    ST_SAME   = 2'd1,
    ST_RANGE  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_WALK_A,
    B_WALK_B,
    B_LINK_ROOT,
    B_LINK_CHILD
  } back_state_t;

  typedef struct packed {
    logic [VERT_W-1:0]          node_a;
    logic [VERT_W-1:0]          node_b;
    logic signed [WEIGHT_W-1:0] weight;
    logic                       last;
    logic                       range_err;
    logic [VIDX_W-1:0]          a_idx;
    logic [VIDX_W-1:0]          b_idx;
  } item_t;

  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic [VIDX_W-1:0]  parent;
    logic [SIZE_W-1:0]  size;
  } mem_word_t;

endpackage

// ===== sv/mefuf_front.sv =====
module mefuf_front import mefuf_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [VERT_W-1:0]          node_a,
  input  logic [VERT_W-1:0]          node_b,
  input  logic signed [WEIGHT_W-1:0] edge_weight,
  input  logic                       last_edge,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [APB_ADDR_W-1:0]      paddr,
  input  logic [APB_DATA_W-1:0]      pwdata,
  output logic [APB_DATA_W-1:0]      prdata,
  output logic                       pready,
  input  logic                       q_full,
  input  logic                       clearing,
  output logic                       push,
  output item_t                      item
);

  logic [VERT_W-1:0] vertex_count;
  logic [CMP_W-1:0]  limit;
  logic [CMP_W-1:0]  a_ext;
  logic [CMP_W-1:0]  b_ext;
  logic              reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_VERTEX_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VERTEX_COUNT_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      vertex_count <= pwdata[VERT_W-1:0];
    end
  end

  assign prdata = reg_hit ? APB_DATA_W'(vertex_count) : '0;

  assign busy = q_full | clearing;
  assign push = start & ~busy;

  always_comb begin
    limit = CMP_W'(vertex_count);
    if (limit > CMP_W'(MAX_VERTICES)) begin
      limit = CMP_W'(MAX_VERTICES);
    end
    a_ext = CMP_W'(node_a);
    b_ext = CMP_W'(node_b);
    item.node_a    = node_a;
    item.node_b    = node_b;
    item.weight    = edge_weight;
    item.last      = last_edge;
    item.range_err = (node_a == '0) || (node_b == '0) || (a_ext > limit) || (b_ext > limit);
    item.a_idx     = VIDX_W'(node_a - VERT_W'(1));
    item.b_idx     = VIDX_W'(node_b - VERT_W'(1));
  end

endmodule

// ===== sv/mefuf_queue.sv =====
module mefuf_queue import mefuf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output item_t head,
  output logic  empty,
  output logic  full
);

  item_t             slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign empty   = (count == '0);
  assign full    = (count == QCNT_W'(QDEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// ===== sv/mefuf_back.sv =====
module mefuf_back import mefuf_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  item_t                      q_head,
  input  logic                       q_empty,
  output logic                       q_pop,
  output logic                       clearing,
  output logic                       done,
  output logic [VERT_W-1:0]          node_a_out,
  output logic [VERT_W-1:0]          node_b_out,
  output logic signed [WEIGHT_W-1:0] edge_weight_out,
  output logic [1:0]                 status,
  output logic [COUNT_W-1:0]         tree_edges,
  output logic                       last_out
);

  mem_word_t mem [MAX_VERTICES];
  mem_word_t rdata;
  mem_word_t ent;
  mem_word_t wdata;
  logic [VIDX_W-1:0] raddr;
  logic [VIDX_W-1:0] waddr;
  logic              we;

  back_state_t state, state_next;
  item_t       item_q, item_next;
  item_t       emit_item;
  logic [VIDX_W-1:0]  cur, cur_next;
  logic [VIDX_W-1:0]  ra, ra_next;
  logic [VIDX_W-1:0]  rb, rb_next;
  logic [SIZE_W-1:0]  size_a, size_a_next;
  logic [SIZE_W-1:0]  size_b, size_b_next;
  logic [COUNT_W-1:0] count, count_next;
  logic [COUNT_W-1:0] emit_count;
  logic [EPOCH_W-1:0] epoch, epoch_next;
  logic [VIDX_W-1:0]  clr_addr, clr_next;
  logic               emit;
  status_t            emit_status;
  logic               a_wins;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // Entries tagged with an older epoch read as a fresh singleton set.
  always_comb begin
    if (rdata.tag == epoch) begin
      ent = rdata;
    end else begin
      ent.tag    = epoch;
      ent.parent = cur;
      ent.size   = SIZE_W'(1);
    end
  end

  assign a_wins   = (size_a >= size_b);
  assign clearing = (state == B_CLEAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_CLEAR;
      count    <= '0;
      epoch    <= '0;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      epoch    <= epoch_next;
      clr_addr <= clr_next;
      done     <= emit;
    end
  end

  always_ff @(posedge clk) begin
    item_q <= item_next;
    cur    <= cur_next;
    ra     <= ra_next;
    rb     <= rb_next;
    size_a <= size_a_next;
    size_b <= size_b_next;
    if (emit) begin
      node_a_out      <= emit_item.node_a;
      node_b_out      <= emit_item.node_b;
      edge_weight_out <= emit_item.weight;
      status          <= emit_status;
      tree_edges      <= emit_count;
      last_out        <= emit_item.last;
    end
  end

  always_comb begin
    state_next  = state;
    item_next   = item_q;
    cur_next    = cur;
    ra_next     = ra;
    rb_next     = rb;
    size_a_next = size_a;
    size_b_next = size_b;
    count_next  = count;
    epoch_next  = epoch;
    clr_next    = clr_addr;
    raddr       = cur;
    we          = 1'b0;
    waddr       = clr_addr;
    wdata       = '0;
    q_pop       = 1'b0;
    emit        = 1'b0;
    emit_status = ST_SAME;
    emit_item   = item_q;

    case (state)
      B_CLEAR: begin
        we           = 1'b1;
        waddr        = clr_addr;
        wdata.tag    = '0;
        wdata.parent = clr_addr;
        wdata.size   = SIZE_W'(1);
        clr_next     = clr_addr + VIDX_W'(1);
        if (clr_addr == LAST_VIDX) begin
          state_next = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          item_next = q_head;
          if (q_head.range_err) begin
            emit        = 1'b1;
            emit_status = ST_RANGE;
            emit_item   = q_head;
          end else begin
            raddr      = q_head.a_idx;
            cur_next   = q_head.a_idx;
            state_next = B_WALK_A;
          end
        end
      end
      B_WALK_A: begin
        if (ent.parent == cur) begin
          ra_next     = cur;
          size_a_next = ent.size;
          raddr       = item_q.b_idx;
          cur_next    = item_q.b_idx;
          state_next  = B_WALK_B;
        end else begin
          raddr    = ent.parent;
          cur_next = ent.parent;
        end
      end
      B_WALK_B: begin
        if (ent.parent == cur) begin
          rb_next     = cur;
          size_b_next = ent.size;
          if (cur == ra) begin
            emit        = 1'b1;
            emit_status = ST_SAME;
            state_next  = B_IDLE;
          end else begin
            state_next = B_LINK_ROOT;
          end
        end else begin
          raddr    = ent.parent;
          cur_next = ent.parent;
        end
      end
      B_LINK_ROOT: begin
        we           = 1'b1;
        waddr        = a_wins ? ra : rb;
        wdata.tag    = epoch;
        wdata.parent = a_wins ? ra : rb;
        wdata.size   = size_a + size_b;
        state_next   = B_LINK_CHILD;
      end
      B_LINK_CHILD: begin
        we           = 1'b1;
        waddr        = a_wins ? rb : ra;
        wdata.tag    = epoch;
        wdata.parent = a_wins ? ra : rb;
        wdata.size   = a_wins ? size_b : size_a;
        count_next   = count + COUNT_W'(1);
        emit         = 1'b1;
        emit_status  = ST_JOINED;
        state_next   = B_IDLE;
      end
      default: begin
        state_next = B_CLEAR;
        clr_next   = '0;
      end
    endcase

    emit_count = count_next;

    // The final edge of a graph starts a new epoch; when the epoch wraps,
    // the whole memory is swept back to singleton sets.
    if (emit && emit_item.last) begin
      count_next = '0;
      epoch_next = epoch + EPOCH_W'(1);
      if (epoch_next == '0) begin
        state_next = B_CLEAR;
        clr_next   = '0;
      end
    end
  end

endmodule

// ===== sv/mst_edge_filter_union_find_unit.sv =====
// Kruskal edge filter over a disjoint-set forest, union by size.
// Edges are presented in ascending weight order on node_a, node_b,
// edge_weight and last_edge, and an item is taken when start is high and
// busy is low. A two-entry queue holds items while the root walks run.
// Each item yields one result on the *_out ports, status and tree_edges,
// marked by done for a single cycle; the receiver cannot stall it.
// The walk unit reports a range error straight from its idle state;
// other edges walk from each endpoint to its root, one memory read per
// parent step (at most log2 of the set size each), and report there if
// the roots are shared, while a join first writes the new root and then
// the child, reporting with the child write. vertex_count is written
// over the APB port at address 0; the user must write it only while
// idle, as the block does not enforce this. After reset, and after
// every 64th graph, the union-find memory is swept, during which busy
// stays high. After the item marked last_edge the forest and the edge
// count start over.
module mst_edge_filter_union_find_unit import mefuf_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [VERT_W-1:0]          node_a,
  input  logic [VERT_W-1:0]          node_b,
  input  logic signed [WEIGHT_W-1:0] edge_weight,
  input  logic                       last_edge,
  output logic                       done,
  output logic [VERT_W-1:0]          node_a_out,
  output logic [VERT_W-1:0]          node_b_out,
  output logic signed [WEIGHT_W-1:0] edge_weight_out,
  output logic [1:0]                 status,
  output logic [COUNT_W-1:0]         tree_edges,
  output logic                       last_out,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [APB_ADDR_W-1:0]      paddr,
  input  logic [APB_DATA_W-1:0]      pwdata,
  output logic [APB_DATA_W-1:0]      prdata,
  output logic                       pready
);

  item_t push_item;
  item_t q_head;
  logic  push;
  logic  q_pop;
  logic  q_empty;
  logic  q_full;
  logic  clearing;

  mefuf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .node_a      (node_a),
    .node_b      (node_b),
    .edge_weight (edge_weight),
    .last_edge   (last_edge),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .q_full      (q_full),
    .clearing    (clearing),
    .push        (push),
    .item        (push_item)
  );

  mefuf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  mefuf_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_head          (q_head),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .clearing        (clearing),
    .done            (done),
    .node_a_out      (node_a_out),
    .node_b_out      (node_b_out),
    .edge_weight_out (edge_weight_out),
    .status          (status),
    .tree_edges      (tree_edges),
    .last_out        (last_out)
  );

endmodule

// ===== sv/mefuf_checker.sv =====
module mefuf_checker import mefuf_pkg::*; (
  input logic                       clk,
  input logic                       rst,
  input logic                       busy,
  input logic                       done,
  input logic [VERT_W-1:0]          node_a_out,
  input logic [VERT_W-1:0]          node_b_out,
  input logic [1:0]                 status,
  input logic [COUNT_W-1:0]         tree_edges,
  input logic                       psel,
  input logic                       penable,
  input logic                       pwrite,
  input logic [APB_ADDR_W-1:0]      paddr,
  input logic [APB_DATA_W-1:0]      pwdata,
  input logic [APB_DATA_W-1:0]      prdata
);

  // The memory sweep after reset keeps the block from taking items.
  a_busy_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low right after reset");

  a_join_counts: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_JOINED |-> tree_edges != '0)
    else $error("joined edge reported with zero tree edges");

  a_endpoints_valid: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_RANGE |-> node_a_out != '0 && node_b_out != '0)
    else $error("zero endpoint passed the range check");

  a_self_loop: assert property (@(posedge clk) disable iff (rst)
    done && node_a_out == node_b_out |-> status != ST_JOINED)
    else $error("self loop joined the tree");

  a_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && paddr[APB_ADDR_W-1:2] == REG_VERTEX_COUNT)
    ##1 (psel && !pwrite && paddr[APB_ADDR_W-1:2] == REG_VERTEX_COUNT)
    |-> prdata[VERT_W-1:0] == $past(pwdata[VERT_W-1:0]))
    else $error("vertex_count readback differs from the value written");

endmodule

bind mst_edge_filter_union_find_unit mefuf_checker u_mefuf_checker (.*);

// ===== tb/tb_top.sv =====
module tb_top;
  import mefuf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 40;
  localparam int NUM_PHASES = 9;

  typedef struct packed {
    logic [VERT_W-1:0]          a;
    logic [VERT_W-1:0]          b;
    logic signed [WEIGHT_W-1:0] w;
    logic                       last;
  } edge_item_t;

  typedef struct packed {
    logic [VERT_W-1:0]          a;
    logic [VERT_W-1:0]          b;
    logic signed [WEIGHT_W-1:0] w;
    status_t                    st;
    logic [COUNT_W-1:0]         cnt;
    logic                       last;
  } verdict_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic                       busy;
  logic [VERT_W-1:0]          node_a = '0;
  logic [VERT_W-1:0]          node_b = '0;
  logic signed [WEIGHT_W-1:0] edge_weight = '0;
  logic                       last_edge = 1'b0;
  logic                       done;
  logic [VERT_W-1:0]          node_a_out;
  logic [VERT_W-1:0]          node_b_out;
  logic signed [WEIGHT_W-1:0] edge_weight_out;
  logic [1:0]                 status;
  logic [COUNT_W-1:0]         tree_edges;
  logic                       last_out;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]      paddr = '0;
  logic [APB_DATA_W-1:0]      pwdata = '0;
  logic [APB_DATA_W-1:0]      prdata;
  logic                       pready;

  mst_edge_filter_union_find_unit i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .node_a(node_a), .node_b(node_b), .edge_weight(edge_weight),
    .last_edge(last_edge), .done(done),
    .node_a_out(node_a_out), .node_b_out(node_b_out),
    .edge_weight_out(edge_weight_out), .status(status),
    .tree_edges(tree_edges), .last_out(last_out),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  int unsigned        forest_parent [0:MAX_VERTICES];
  int unsigned        forest_size [0:MAX_VERTICES];
  logic [COUNT_W-1:0] tree_count;
  logic [VERT_W-1:0]  vertex_limit;

  edge_item_t edge_q[$];
  verdict_t   verdict_q[$];
  edge_item_t next_item;
  logic       took = 1'b0;
  int         issued = 0;
  int         queued = 0;
  int         mismatches = 0;
  int         stall_cycles = 0;
  int         n_joined = 0;
  int         n_same = 0;
  int         n_range = 0;
  int         n_graphs = 0;

  function automatic void forest_reset();
    for (int v = 0; v <= MAX_VERTICES; v++) begin
      forest_parent[v] = v;
      forest_size[v] = 1;
    end
    tree_count = '0;
  endfunction

  function automatic int unsigned find_root(int unsigned start_v);
    int unsigned v;
    int unsigned steps;
    v = start_v;
    steps = 0;
    while (v <= MAX_VERTICES && forest_parent[v] != v && steps < MAX_VERTICES) begin
      v = forest_parent[v];
      steps++;
    end
    return v;
  endfunction

  function automatic verdict_t judge_edge(edge_item_t e);
    verdict_t    r;
    int unsigned lim;
    int unsigned ra;
    int unsigned rb;
    lim = (vertex_limit > MAX_VERTICES) ? MAX_VERTICES : vertex_limit;
    r.a = e.a;
    r.b = e.b;
    r.w = e.w;
    r.last = e.last;
    if (e.a == 0 || e.b == 0 || e.a > lim || e.b > lim) begin
      r.st = ST_RANGE;
    end else begin
      ra = find_root(e.a);
      rb = find_root(e.b);
      if (ra == rb) begin
        r.st = ST_SAME;
      end else begin
        if (forest_size[ra] >= forest_size[rb]) begin
          forest_size[ra] += forest_size[rb];
          forest_parent[rb] = ra;
        end else begin
          forest_size[rb] += forest_size[ra];
          forest_parent[ra] = rb;
        end
        tree_count = tree_count + 1'b1;
        r.st = ST_JOINED;
      end
    end
    r.cnt = tree_count;
    if (e.last) forest_reset();
    return r;
  endfunction

  function automatic void note_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH %s", what);
  endfunction

  // An item is taken at a rising edge with start high and busy low.
  always @(posedge clk) begin
    took <= !rst && start && !busy;
    if (!rst && start && !busy) begin
      verdict_q.push_back(judge_edge('{node_a, node_b, edge_weight, last_edge}));
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || took) begin
      if (edge_q.size() != 0 &&
          !((issued < 700 || issued >= 1000) && $urandom_range(0, 99) < 19)) begin
        next_item = edge_q.pop_front();
        start <= 1'b1;
        node_a <= next_item.a;
        node_b <= next_item.b;
        edge_weight <= next_item.w;
        last_edge <= next_item.last;
        issued++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    verdict_t want;
    if (!rst) begin
      if (done) begin
        if (verdict_q.size() == 0) begin
          note_mismatch($sformatf("result with nothing expected: a=%0d b=%0d st=%0d",
                                  node_a_out, node_b_out, status));
        end else begin
          want = verdict_q.pop_front();
          if (node_a_out !== want.a || node_b_out !== want.b ||
              edge_weight_out !== want.w || status !== want.st ||
              tree_edges !== want.cnt || last_out !== want.last) begin
            note_mismatch($sformatf(
              "exp a=%0d b=%0d w=%0d st=%0d cnt=%0d last=%0b got a=%0d b=%0d w=%0d st=%0d cnt=%0d last=%0b",
              want.a, want.b, want.w, want.st, want.cnt, want.last,
              node_a_out, node_b_out, edge_weight_out, status, tree_edges, last_out));
          end
          case (want.st)
            ST_JOINED: n_joined++;
            ST_SAME:   n_same++;
            default:   n_range++;
          endcase
          if (want.last) n_graphs++;
        end
      end
      if ((start && !busy) || done) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic push_edge(input int a, input int b, input logic [WEIGHT_W-1:0] w,
                           input logic last);
    edge_q.push_back('{VERT_W'(a), VERT_W'(b), w, last});
    queued++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (edge_q.size() != 0 || start || verdict_q.size() != 0 || busy) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_vertex_count(input logic [APB_DATA_W-1:0] value);
    logic [APB_DATA_W-1:0] rd;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_VERTEX_COUNT, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    vertex_limit = value[VERT_W-1:0];
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd[VERT_W-1:0] !== value[VERT_W-1:0])
      note_mismatch($sformatf("vertex_count read %0d, wrote %0d", rd, value));
  endtask

  // Random edges among vertices 1..n, with a few out-of-range endpoints and
  // stray graph ends mixed in; a balanced graph first merges pairs, then
  // pairs of pairs, so the root walks get as long as the size allows.
  task automatic queue_graph(input int n, input int edges, input int eff,
                             input bit balanced);
    logic [WEIGHT_W-1:0] w;
    int a;
    int b;
    int r;
    w = $urandom;
    if (balanced) begin
      for (int s = 1; s < n; s = s * 2) begin
        for (int i = 1; i + s <= n; i = i + 2 * s) begin
          w = w + $urandom_range(0, 500);
          push_edge(i, i + s, w, 1'b0);
        end
      end
    end
    for (int k = 0; k < edges; k++) begin
      r = $urandom_range(0, 99);
      w = w + $urandom_range(0, 500);
      if (n == 0 || r < 6) begin
        a = $urandom_range(0, 2047);
        b = $urandom_range(0, 2047);
        if (n != 0 && eff < 2047) begin
          if ($urandom_range(0, 1)) a = $urandom_range(0, 1) ? 0 : $urandom_range(eff + 1, 2047);
          else b = $urandom_range(0, 1) ? 0 : $urandom_range(eff + 1, 2047);
        end
      end else begin
        a = $urandom_range(1, n);
        b = $urandom_range(1, n);
      end
      push_edge(a, b, w, (k == edges - 1) || (r >= 6 && r < 9));
    end
  endtask

  initial begin
    int phase_vc [NUM_PHASES];
    int phase_items [NUM_PHASES];
    int eff;
    int n;
    int target;
    int span;
    int k_edges;
    phase_vc = '{1024, 2047, 37, 2, 1, 0, 1023, 512, 1024};
    phase_items = '{350, 200, 180, 60, 30, 30, 200, 200, 200};
    forest_reset();
    vertex_limit = VERTEX_COUNT_RESET;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    wait_idle();

    write_vertex_count(1024);
    push_edge(1, 2, 32'h8000_0000, 1'b0);
    push_edge(3, 4, 32'hFFFF_FFFF, 1'b0);
    push_edge(1, 3, 32'h0000_0000, 1'b0);
    push_edge(2, 4, 32'h0000_0001, 1'b0);
    push_edge(5, 5, 32'h0000_0002, 1'b0);
    push_edge(0, 5, 32'h5555_5555, 1'b0);
    push_edge(5, 0, 32'hAAAA_AAAA, 1'b0);
    push_edge(1025, 1, 32'h0000_0100, 1'b0);
    push_edge(2047, 2047, 32'h0000_0200, 1'b0);
    push_edge(1024, 1023, 32'h0000_0300, 1'b0);
    push_edge(1024, 5, 32'h0000_0400, 1'b0);
    push_edge(5, 1, 32'h0000_0500, 1'b0);
    push_edge(1024, 2, 32'h7FFF_FFFF, 1'b1);
    push_edge(1, 2, 32'h0000_0010, 1'b1);
    push_edge(0, 0, 32'h0000_0020, 1'b1);
    push_edge(10, 20, 32'h0000_0030, 1'b0);
    push_edge(20, 30, 32'h0000_0040, 1'b0);
    wait_idle();
    // The bound shrinks in the middle of a graph; the forest is kept.
    write_vertex_count(25);
    push_edge(30, 10, 32'h0000_0050, 1'b0);
    push_edge(10, 20, 32'h0000_0060, 1'b1);
    wait_idle();
    write_vertex_count(2047);
    push_edge(1024, 1, 32'h0000_0070, 1'b0);
    push_edge(1025, 1, 32'h0000_0080, 1'b0);
    push_edge(2047, 1, 32'h0000_0090, 1'b1);
    wait_idle();
    write_vertex_count(0);
    push_edge(1, 1, 32'h0000_00A0, 1'b1);
    wait_idle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_vertex_count(phase_vc[p]);
      eff = (phase_vc[p] > MAX_VERTICES) ? MAX_VERTICES : phase_vc[p];
      target = queued + phase_items[p];
      if (p == 0) queue_graph(256, 40, eff, 1'b1);
      while (queued < target) begin
        span = target - queued;
        if (eff >= 64 && span >= 80 && $urandom_range(0, 9) == 0) begin
          queue_graph(64, $urandom_range(4, 16), eff, 1'b1);
        end else begin
          n = (eff < 2) ? eff : $urandom_range(2, (eff < 48) ? eff : 48);
          k_edges = $urandom_range(n + 1, 2 * n + 2);
          queue_graph(n, (k_edges < span) ? k_edges : span, eff, 1'b0);
        end
      end
      wait_idle();
    end

    $display("Covered %0d edges in %0d graphs over %0d vertex_count settings.",
             issued, n_graphs, NUM_PHASES + 4);
    $display("Outcomes: %0d joined, %0d already connected, %0d out of range; %0d mismatches.",
             n_joined, n_same, n_range, mismatches);
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
